### rtl/core/dhbu_pkg.sv
// Shared types and constants for the debug halt and breakpoint unit.
// Holds the command codes, the chain token format and the sizing constants.
// No dependencies.
`default_nettype none

package dhbu_pkg;

  // Number of breakpoint cells in the chain
  localparam int unsigned SLOTS   = 16;
  // Compared address width
  localparam int unsigned ADDR_W  = 16;
  // Packed result width, rounded up to whole bytes
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned OP_W    = 3;

  // Debugger and CPU request codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_STOP     = 3'd1,
    OP_RESUME   = 3'd2,
    OP_UNTIL    = 3'd3,
    OP_STEP     = 3'd4,
    OP_CONTINUE = 3'd5,
    OP_ADD      = 3'd6,
    OP_DELETE   = 3'd7
  } op_t;

  // What a token asks of each cell it passes
  typedef enum logic [1:0] {
    K_MATCH = 2'd0,
    K_ADD   = 2'd1,
    K_DEL   = 2'd2
  } kind_t;

  // Token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic              active;
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic              flag;   // match seen, or slot claimed / entry removed
  } tok_t;

endpackage

`default_nettype wire

### rtl/core/dhbu_cell.sv
// One breakpoint slot: a valid bit, a stored address and a token stage.
// Depends on dhbu_pkg for the token type.
`default_nettype none

module dhbu_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  dhbu_pkg::tok_t tok_i,
  output dhbu_pkg::tok_t tok_o
);
  import dhbu_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  tok_t              tok_r, tok_nxt;
  logic              hit;

  assign hit = valid_r && (addr_r == tok_i.addr);

  // Act on the passing token and forward it
  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    tok_nxt   = tok_i;
    if (tok_i.active) begin
      case (tok_i.kind)
        K_MATCH: begin
          tok_nxt.flag = tok_i.flag | hit;
        end
        K_ADD: begin
          // claim this slot if it is the first free one
          if (!tok_i.flag && !valid_r) begin
            valid_nxt    = 1'b1;
            addr_nxt     = tok_i.addr;
            tok_nxt.flag = 1'b1;
          end
        end
        K_DEL: begin
          // drop the first valid entry that matches, or any when address is zero
          if (!tok_i.flag && valid_r &&
              ((tok_i.addr == '0) || (addr_r == tok_i.addr))) begin
            valid_nxt    = 1'b0;
            tok_nxt.flag = 1'b1;
          end
        end
        default: begin
          tok_nxt = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

### rtl/core/debug_halt_breakpoint_unit.sv
// Debug halt controller: run state, stop/until/step/continue modes, breakpoint chain.
// Requests that skip the table go from idle to done, which loads the result register when the
// output is free; ticks in continue or until mode with no stop pending, and add/delete while
// stopped, walk the chain first. No new request is taken until the last result is loaded.
// Reset (rst_n low, synchronous): stopped, no pending stop, all modes clear, table empty.
// Uses dhbu_pkg and dhbu_cell.
`default_nettype none

module debug_halt_breakpoint_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration: start_halted
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  // Request channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // [15:0] address
  input  logic [dhbu_pkg::OP_W-1:0] in_tuser,   // [2:0] operation
  // Result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [0] halt, [1] by_stop_request, [2] by_breakpoint, [3] by_until, [4] by_step,
  // [20:5] halt_address, [21] rejected, [22] running, [23] zero
  output logic [dhbu_pkg::OUT_W-1:0] out_tdata
);
  import dhbu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              flag_r, flag_nxt;
  tok_t              launch_r, launch_nxt;

  logic              run_r, run_nxt;
  logic              pend_r, pend_nxt;
  logic              cont_r, cont_nxt;
  logic              until_r, until_nxt;
  logic              step_r, step_nxt;
  logic [ADDR_W-1:0] target_r, target_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  tok_t              chain [SLOTS+1];
  logic              in_fire, out_free, need_walk;
  op_t               in_op;

  // Breakpoint cell chain
  assign chain[0] = launch_r;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dhbu_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  assign in_op     = op_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Table walk is needed for live breakpoint checks and for table edits
  always_comb begin
    need_walk = 1'b0;
    case (in_op)
      OP_TICK:   need_walk = !pend_r && (cont_r || until_r);
      OP_ADD:    need_walk = !run_r;
      OP_DELETE: need_walk = !run_r;
      default:   need_walk = 1'b0;
    endcase
  end

  // Sequence one request and compute its result
  always_comb begin
    logic hlt, b_stop, b_bp, b_until, b_step, rej;
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    flag_nxt      = flag_r;
    launch_nxt    = launch_r;
    launch_nxt.active = 1'b0;
    run_nxt       = run_r;
    pend_nxt      = pend_r;
    cont_nxt      = cont_r;
    until_nxt     = until_r;
    step_nxt      = step_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    hlt = 1'b0; b_stop = 1'b0; b_bp = 1'b0; b_until = 1'b0; b_step = 1'b0; rej = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_op;
          addr_nxt = in_tdata[ADDR_W-1:0];
          flag_nxt = 1'b0;
          if (need_walk) begin
            launch_nxt.active = 1'b1;
            launch_nxt.addr   = in_tdata[ADDR_W-1:0];
            launch_nxt.flag   = 1'b0;
            launch_nxt.kind   = (in_op == OP_TICK) ? K_MATCH :
                                (in_op == OP_ADD)  ? K_ADD : K_DEL;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        // capture the token as it leaves the last cell
        if (chain[SLOTS].active) begin
          flag_nxt  = chain[SLOTS].flag;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          case (op_r)
            OP_TICK: begin
              if (pend_r) begin
                pend_nxt = 1'b0;
                hlt      = 1'b1;
                b_stop   = 1'b1;
              end else begin
                b_bp    = (cont_r || until_r) && flag_r;
                b_until = until_r && (target_r == addr_r);
                b_step  = step_r;
                if (b_bp || b_until) cont_nxt = 1'b0;
                if (b_until) begin
                  until_nxt  = 1'b0;
                  target_nxt = '0;
                end
                if (b_step) step_nxt = 1'b0;
                hlt = b_bp || b_until || b_step;
                if (hlt) run_nxt = 1'b0;
              end
            end
            OP_STOP: begin
              if (!run_r) begin
                rej = 1'b1;
              end else begin
                run_nxt  = 1'b0;
                pend_nxt = 1'b1;
              end
            end
            OP_RESUME: begin
              if (run_r) rej = 1'b1;
              else       run_nxt = 1'b1;
            end
            default: begin
              if (run_r) begin
                rej = 1'b1;
              end else begin
                case (op_r)
                  OP_UNTIL: begin
                    until_nxt  = 1'b1;
                    target_nxt = addr_r;
                    run_nxt    = 1'b1;
                  end
                  OP_STEP: begin
                    step_nxt = 1'b1;
                    run_nxt  = 1'b1;
                  end
                  OP_CONTINUE: begin
                    cont_nxt = 1'b1;
                    run_nxt  = 1'b1;
                  end
                  OP_ADD:  rej = !flag_r;
                  default: rej = 1'b0;
                endcase
              end
            end
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, run_nxt, rej,
                           hlt ? addr_r : {ADDR_W{1'b0}},
                           b_step, b_until, b_bp, b_stop, hlt};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // configuration load of the run flag
    if (cfg_we) run_nxt = !cfg_wdata;
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    flag_r     <= flag_nxt;
    target_r   <= target_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r         <= S_IDLE;
      launch_r.active <= 1'b0;
      run_r           <= 1'b0;
      pend_r          <= 1'b0;
      cont_r          <= 1'b0;
      until_r         <= 1'b0;
      step_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      cont_r      <= cont_nxt;
      until_r     <= until_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // At most one token among the launch register and the last two cells
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({chain[SLOTS].active, chain[SLOTS-1].active, chain[0].active}))
    else $error("more than one token in the breakpoint chain");

  // A token leaves the chain only while a walk is waiting for it
  a_exit_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chain[SLOTS].active |-> (state_r == S_WALK))
    else $error("token left the chain outside a walk");

  // An accepted request blocks further requests until its result is loaded
  a_accept_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second request accepted while one is in progress");

  // A halt is never reported as a refused request
  a_halt_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> !out_tdata[21])
    else $error("halt reported together with a rejection");

endmodule

`default_nettype wire
